FILE: src/fbw_pkg.sv
// Package for the bilinear flow warp block: widths, register indexes, types.
// No dependencies.
package fbw_pkg;
  localparam int unsigned CoordW   = 9;
  localparam int unsigned PixW     = 16;
  localparam int unsigned FlowW    = 18;
  localparam int unsigned FracW    = 8;
  localparam int unsigned CfgW     = 10;
  localparam int unsigned IntW     = 11;  // signed integer part of a sample coordinate
  localparam int unsigned BankAw   = 16;  // 8 bits of row, 8 bits of column per bank
  localparam int unsigned BankDepth = 65536;
  localparam int unsigned QDepth   = 2;

  localparam logic [0:0] RegWidth  = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;

  localparam logic FuncLoad = 1'b0;
  localparam logic FuncWarp = 1'b1;

  // Classified warp job handed from the front to the back.
  typedef struct packed {
    logic [FracW-1:0]  fx;
    logic [FracW-1:0]  fy;
    logic              x0_odd;
    logic              y0_odd;
    logic [3:0]        in_frame;   // a, b, c, d
    logic [PixW-1:0]   pix;
  } job_t;
endpackage

FILE: src/fbw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fbw_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule

FILE: src/fbw_front.sv
// Front: takes transactions, writes loads into four row/column parity banks,
// and for warps computes the neighbour addresses and bounds. Uses fbw_pkg, fbw_ram.
module fbw_front import fbw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic              func_i,
  input  logic [CoordW-1:0] pos_x_i,
  input  logic [CoordW-1:0] pos_y_i,
  input  logic [PixW-1:0]   pixel_i,
  input  logic [FlowW-1:0]  flow_u_i,
  input  logic [FlowW-1:0]  flow_v_i,
  input  logic [CfgW-1:0]   width_i,
  input  logic [CfgW-1:0]   height_i,
  output logic              job_valid_o,
  output job_t              job_o,
  output logic [PixW-1:0]   bank_o [4]   // indexed by {y_odd, x_odd}
);
  localparam int unsigned SW = FlowW + 2;

  logic signed [SW-1:0] sx, sy;
  logic signed [IntW-1:0] x0, y0, x1, y1;
  logic [CfgW-1:0] w_eff, h_eff;
  logic inx0, inx1, iny0, iny1;
  logic [7:0] xe, xo, ye, yo;   // bank columns/rows for even and odd coordinates

  // Form sample coordinates and split them
  assign sx = $signed({3'b000, pos_x_i, {FracW{1'b0}}}) + SW'($signed(flow_u_i));
  assign sy = $signed({3'b000, pos_y_i, {FracW{1'b0}}}) + SW'($signed(flow_v_i));
  assign x0 = sx[FracW +: IntW];
  assign y0 = sy[FracW +: IntW];
  assign x1 = x0 + IntW'(1);
  assign y1 = y0 + IntW'(1);

  // Clamp frame size to the store and check bounds
  assign w_eff = (width_i  > CfgW'(512)) ? CfgW'(512) : width_i;
  assign h_eff = (height_i > CfgW'(512)) ? CfgW'(512) : height_i;
  assign inx0 = !x0[IntW-1] && ($unsigned(x0[IntW-2:0]) < w_eff);
  assign inx1 = !x1[IntW-1] && ($unsigned(x1[IntW-2:0]) < w_eff);
  assign iny0 = !y0[IntW-1] && ($unsigned(y0[IntW-2:0]) < h_eff);
  assign iny1 = !y1[IntW-1] && ($unsigned(y1[IntW-2:0]) < h_eff);

  // Even neighbour coordinate: the one of x0, x1 that is even
  assign xe = x0[0] ? x1[8:1] : x0[8:1];
  assign xo = x0[0] ? x0[8:1] : x1[8:1];
  assign ye = y0[0] ? y1[8:1] : y0[8:1];
  assign yo = y0[0] ? y0[8:1] : y1[8:1];

  logic warp, load;
  assign warp = fire_i && (func_i == FuncWarp);
  assign load = fire_i && (func_i == FuncLoad);

  for (genvar g = 0; g < 4; g++) begin : g_bank
    logic [BankAw-1:0] ra;
    logic [7:0] rr, cc;
    assign rr = g[1] ? yo : ye;
    assign cc = g[0] ? xo : xe;
    assign ra = {rr, cc};
    fbw_ram #(.Width(PixW), .Depth(BankDepth)) u_bank (
      .clk_i,
      .we_i   (load && (pos_y_i[0] == g[1]) && (pos_x_i[0] == g[0])),
      .waddr_i({pos_y_i[8:1], pos_x_i[8:1]}),
      .wdata_i(pixel_i),
      .re_i   (warp),
      .raddr_i(ra),
      .rdata_o(bank_o[g])
    );
  end

  // Register the job alongside the bank read
  logic job_valid_q;
  job_t job_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) job_valid_q <= 1'b0;
    else         job_valid_q <= warp;
  end
  always_ff @(posedge clk_i) begin
    if (warp) begin
      job_q.fx       <= sx[FracW-1:0];
      job_q.fy       <= sy[FracW-1:0];
      job_q.x0_odd   <= x0[0];
      job_q.y0_odd   <= y0[0];
      job_q.in_frame <= {inx1 && iny1, inx0 && iny1, inx1 && iny0, inx0 && iny0};
      job_q.pix      <= pixel_i;
    end
  end
  assign job_valid_o = job_valid_q;
  assign job_o = job_q;
endmodule

FILE: src/fbw_back.sv
// Back: substitutes outside neighbours, runs the two-stage bilinear blend and
// feeds a small result queue. Uses fbw_pkg.
module fbw_back import fbw_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  input  job_t            job_i,
  input  logic [PixW-1:0] bank_i [4],
  input  logic            pop_i,
  output logic            empty_o,
  output logic [2:0]      in_flight_o,
  output logic [PixW-1:0] warped_pixel_o,
  output logic            sample_valid_o
);
  localparam int unsigned One = 1 << FracW;
  localparam int unsigned HW = PixW + FracW + 1;
  localparam int unsigned AccW = HW + FracW + 1;

  logic [PixW-1:0] a, b, c, d, ra, rb, rc, rd;
  logic [FracW:0] wx0, wx1;
  logic [HW-1:0] top, bot;

  // Route banks back to neighbours and replace outside ones
  assign ra = bank_i[{job_i.y0_odd, job_i.x0_odd}];
  assign rb = bank_i[{job_i.y0_odd, !job_i.x0_odd}];
  assign rc = bank_i[{!job_i.y0_odd, job_i.x0_odd}];
  assign rd = bank_i[{!job_i.y0_odd, !job_i.x0_odd}];
  assign a = job_i.in_frame[0] ? ra : job_i.pix;
  assign b = job_i.in_frame[1] ? rb : job_i.pix;
  assign c = job_i.in_frame[2] ? rc : job_i.pix;
  assign d = job_i.in_frame[3] ? rd : job_i.pix;
  assign wx1 = {1'b0, job_i.fx};
  assign wx0 = (FracW+1)'(One) - wx1;
  assign top = HW'(a) * HW'(wx0) + HW'(b) * HW'(wx1);
  assign bot = HW'(c) * HW'(wx0) + HW'(d) * HW'(wx1);

  // Horizontal stage register
  logic s1_valid_q, s1_ok_q;
  logic [HW-1:0] top_q, bot_q;
  logic [FracW-1:0] fy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else         s1_valid_q <= job_valid_i;
  end
  always_ff @(posedge clk_i) begin
    top_q   <= top;
    bot_q   <= bot;
    fy_q    <= job_i.fy;
    s1_ok_q <= &job_i.in_frame;
  end

  // Vertical blend and rounding
  logic [FracW:0] wy0, wy1;
  logic [AccW-1:0] acc;
  logic [PixW-1:0] res;
  assign wy1 = {1'b0, fy_q};
  assign wy0 = (FracW+1)'(One) - wy1;
  assign acc = AccW'(top_q) * AccW'(wy0) + AccW'(bot_q) * AccW'(wy1)
             + AccW'(1 << (2*FracW-1));
  assign res = acc[2*FracW +: PixW];

  // Result queue: deep enough for everything in flight
  localparam int unsigned FD = 4;
  logic [PixW:0] fifo_q [FD];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q, inflight;
  logic push, pop;
  assign push = s1_valid_q;
  assign pop  = pop_i && (cnt_q != 3'd0);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 2'd1;
      if (pop)  rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + 3'(push) - 3'(pop);
    end
  end
  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= {s1_ok_q, res};
  end
  assign empty_o = (cnt_q == 3'd0);
  assign {sample_valid_o, warped_pixel_o} = fifo_q[rp_q];
  assign inflight = cnt_q + 3'(job_valid_i) + 3'(s1_valid_q);
  assign in_flight_o = inflight;
endmodule

FILE: src/flow_bilinear_warp.sv
// Channel   | Dir | Handshake            | Payload
// ----------+-----+----------------------+------------------------------------------
// input     | in  | push / full          | func, pos_x, pos_y, pixel, flow_u, flow_v
// result    | out | empty / pop          | warped_pixel, sample_valid
// config    | in  | cfg_we_i             | cfg_idx_i, cfg_data_i
// One transaction per cycle while full is low. A warp result passes, in order, the
// bank read, horizontal blend and vertical blend into a four-entry result queue.
// Four parity banks serve all four neighbours in one parallel read; a load writes one.
// full rises when queue plus pipeline could reach four; reset clears control only,
// the frame store is undefined until loaded. Uses fbw_pkg, fbw_front, fbw_back.
module flow_bilinear_warp import fbw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic              func_i,
  input  logic [CoordW-1:0] pos_x_i,
  input  logic [CoordW-1:0] pos_y_i,
  input  logic [PixW-1:0]   pixel_i,
  input  logic [FlowW-1:0]  flow_u_i,
  input  logic [FlowW-1:0]  flow_v_i,
  output logic              empty,
  input  logic              pop,
  output logic [PixW-1:0]   warped_pixel_o,
  output logic              sample_valid_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [CfgW-1:0]   cfg_data_i
);
  logic [CfgW-1:0] width_q, height_q;
  logic fire, job_valid;
  job_t job;
  logic [PixW-1:0] bank [4];
  logic [2:0] in_flight;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgW'(512);
      height_q <= CfgW'(512);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegWidth)  width_q  <= cfg_data_i;
      if (cfg_idx_i == RegHeight) height_q <= cfg_data_i;
    end
  end

  // Hold off new transactions while the result queue could overflow
  assign full = (in_flight >= 3'd4);
  assign fire = push && !full;

  fbw_front u_front (
    .clk_i, .rst_ni, .fire_i(fire), .func_i, .pos_x_i, .pos_y_i, .pixel_i,
    .flow_u_i, .flow_v_i, .width_i(width_q), .height_i(height_q),
    .job_valid_o(job_valid), .job_o(job), .bank_o(bank)
  );

  fbw_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_i(job), .bank_i(bank),
    .pop_i(pop), .empty_o(empty), .in_flight_o(in_flight),
    .warped_pixel_o, .sample_valid_o
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_flight <= 3'd4) else $error("result queue overflow");
  a_warp_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && func_i == FuncWarp) |=> job_valid) else $error("warp lost");
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && func_i == FuncLoad) |=> !job_valid) else $error("load made a job");
endmodule
